>>> design/bgb_pkg.sv
// Package for the bit-granular buffer.
// Holds action and status codes, field widths and the chunk mask helper.
// No dependencies.
package bgb_pkg;

    localparam int CAPACITY_BITS_DEFAULT = 4096;

    localparam int ACTION_W = 3;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 4;
    localparam int POS_W    = 13;
    localparam int DELTA_W  = 14;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_STORE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_READ     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEEK_ABS = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEEK_REL = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERRUN = 2'd2;

    localparam logic [DATA_W-1:0] FULL_BYTE = 8'hff;
    localparam logic [COUNT_W-1:0] MAX_CHUNK = 4'd8;

    // Keeps the top n bits of a byte.
    function automatic logic [DATA_W-1:0] head_mask(input logic [COUNT_W-1:0] n);
        return ~(FULL_BYTE >> n);
    endfunction

endpackage

>>> design/bit_granular_buffer_top.sv
// Top level of the bit-granular buffer: control, cursors and result register.
// Depends on bgb_pkg and bgb_store.
//
//   Channel  Handshake            Fields
//   input    in_valid, in_ready   action, chunk_data, bit_count, seek_position, seek_delta
//   output   out_valid, out_ready read_data, stored_bits, consumed_bits, all_consumed, status
//
// An item is taken while idle, and the two bytes under the read cursor are then read
// from the banked byte store; the exec state computes, writes back and loads the result.
// A new item is taken whenever the control is idle, even while a result waits.
// An item stalls in the exec state only while the previous result is not taken.
// Reset clears both counts; the byte store is not cleared and needs no sweep.
module bit_granular_buffer_top #(
    parameter int CAPACITY_BITS = bgb_pkg::CAPACITY_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bgb_pkg::ACTION_W-1:0]   action,
    input  logic [bgb_pkg::DATA_W-1:0]     chunk_data,
    input  logic [bgb_pkg::COUNT_W-1:0]    bit_count,
    input  logic [bgb_pkg::POS_W-1:0]      seek_position,
    input  logic signed [bgb_pkg::DELTA_W-1:0] seek_delta,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bgb_pkg::DATA_W-1:0]     read_data,
    output logic [bgb_pkg::POS_W-1:0]      stored_bits,
    output logic [bgb_pkg::POS_W-1:0]      consumed_bits,
    output logic                           all_consumed,
    output logic [bgb_pkg::STATUS_W-1:0]   status
);

    localparam int NUM_BYTES = (CAPACITY_BITS + 7) / 8;
    localparam int BW = $clog2(NUM_BYTES);
    localparam int CW = $clog2(CAPACITY_BITS + 1);
    localparam int PW = (CW > bgb_pkg::POS_W) ? CW : bgb_pkg::POS_W;
    localparam int SW = ((CW > bgb_pkg::DELTA_W) ? CW : bgb_pkg::DELTA_W) + 2;
    localparam logic [CW:0] CAP = (CW + 1)'(CAPACITY_BITS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                               state_reg;
    logic                               state_next;
    logic [bgb_pkg::ACTION_W-1:0]       action_reg;
    logic [bgb_pkg::DATA_W-1:0]         chunk_reg;
    logic [bgb_pkg::COUNT_W-1:0]        count_reg;
    logic [bgb_pkg::POS_W-1:0]          pos_reg;
    logic signed [bgb_pkg::DELTA_W-1:0] delta_reg;
    logic [CW-1:0]                      wc_reg;
    logic [CW-1:0]                      wc_next;
    logic [CW-1:0]                      rc_reg;
    logic [CW-1:0]                      rc_next;
    logic [bgb_pkg::DATA_W-1:0]         tail_reg;
    logic [bgb_pkg::DATA_W-1:0]         tail_next;
    logic                               out_valid_reg;
    logic [bgb_pkg::DATA_W-1:0]         data_reg;
    logic [bgb_pkg::DATA_W-1:0]         data_next;
    logic [bgb_pkg::STATUS_W-1:0]       status_reg;
    logic [bgb_pkg::STATUS_W-1:0]       status_next;

    logic                               accept;
    logic                               exec_go;
    logic [bgb_pkg::COUNT_W-1:0]        count_in;
    logic [2*bgb_pkg::DATA_W-1:0]       rd_window;
    logic [2*bgb_pkg::DATA_W-1:0]       rd_shift;
    logic [bgb_pkg::DATA_W-1:0]         chunk_mask;
    logic [2*bgb_pkg::DATA_W-1:0]       wr_shift;
    logic [bgb_pkg::DATA_W-1:0]         wr_hi;
    logic [bgb_pkg::DATA_W-1:0]         wr_lo;
    logic [2:0]                         wr_off;
    logic [2:0]                         rd_off;
    logic [bgb_pkg::COUNT_W:0]          wr_end;
    logic                               wr_span;
    logic                               wr_en;
    logic [CW:0]                        wc_sum;
    logic [CW:0]                        rc_sum;
    logic [PW-1:0]                      pos_ext;
    logic [PW-1:0]                      wc_ext;
    logic signed [SW-1:0]               rc_s;
    logic signed [SW-1:0]               wc_s;
    logic signed [SW-1:0]               target_s;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign count_in = (bit_count > bgb_pkg::MAX_CHUNK) ? bgb_pkg::MAX_CHUNK : bit_count;

    bgb_store #(
        .NUM_BYTES(NUM_BYTES),
        .BW       (BW)
    ) u_store (
        .clk      (clk),
        .rd_en    (accept),
        .rd_byte  (BW'(rc_reg >> 3)),
        .rd_window(rd_window),
        .wr_en    (wr_en),
        .wr_span  (wr_span),
        .wr_byte  (BW'(wc_reg >> 3)),
        .wr_hi    (wr_hi),
        .wr_lo    (wr_lo)
    );

    assign wr_off     = wc_reg[2:0];
    assign rd_off     = rc_reg[2:0];
    assign chunk_mask = chunk_reg & bgb_pkg::head_mask(count_reg);
    assign wr_shift   = {chunk_mask, {bgb_pkg::DATA_W{1'b0}}} >> wr_off;
    assign wr_hi      = (tail_reg & bgb_pkg::head_mask({1'b0, wr_off})) | wr_shift[15:8];
    assign wr_lo      = wr_shift[7:0];
    assign wr_end     = {2'b00, wr_off} + {1'b0, count_reg};
    assign wr_span    = (wr_end > (bgb_pkg::COUNT_W + 1)'(bgb_pkg::MAX_CHUNK));
    assign wc_sum     = {1'b0, wc_reg} + (CW + 1)'(count_reg);
    assign rc_sum     = {1'b0, rc_reg} + (CW + 1)'(count_reg);
    assign rd_shift   = rd_window << rd_off;
    assign pos_ext    = PW'(pos_reg);
    assign wc_ext     = PW'(wc_reg);
    assign rc_s       = SW'(rc_reg);
    assign wc_s       = SW'(wc_reg);
    assign target_s   = rc_s + SW'(delta_reg);

    assign wr_en = exec_go && (action_reg == bgb_pkg::ACT_STORE) && (count_reg != '0)
                   && (wc_sum <= CAP);

    always_comb
    begin
        wc_next     = wc_reg;
        rc_next     = rc_reg;
        tail_next   = tail_reg;
        data_next   = '0;
        status_next = bgb_pkg::STAT_OK;
        case (action_reg)
            bgb_pkg::ACT_CLEAR:
            begin
                wc_next = '0;
                rc_next = '0;
            end
            bgb_pkg::ACT_STORE:
            begin
                if (count_reg != '0)
                begin
                    if (wc_sum > CAP)
                    begin
                        status_next = bgb_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        wc_next   = CW'(wc_sum);
                        tail_next = (wr_end >= (bgb_pkg::COUNT_W + 1)'(bgb_pkg::MAX_CHUNK))
                                    ? wr_lo : wr_hi;
                    end
                end
            end
            bgb_pkg::ACT_READ:
            begin
                if (count_reg != '0)
                begin
                    if (rc_sum > {1'b0, wc_reg})
                    begin
                        status_next = bgb_pkg::STAT_UNDERRUN;
                    end
                    else
                    begin
                        data_next = rd_shift[15:8] & bgb_pkg::head_mask(count_reg);
                        rc_next   = CW'(rc_sum);
                    end
                end
            end
            bgb_pkg::ACT_SEEK_ABS:
            begin
                rc_next = (pos_ext > wc_ext) ? wc_reg : CW'(pos_ext);
            end
            bgb_pkg::ACT_SEEK_REL:
            begin
                if (target_s < 0)
                begin
                    rc_next = '0;
                end
                else if (target_s > wc_s)
                begin
                    rc_next = wc_reg;
                end
                else
                begin
                    rc_next = CW'(target_s);
                end
            end
            default:
            begin
                wc_next = wc_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wc_reg        <= '0;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                wc_reg        <= wc_next;
                rc_reg        <= rc_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            chunk_reg  <= chunk_data;
            count_reg  <= count_in;
            pos_reg    <= seek_position;
            delta_reg  <= seek_delta;
        end
        if (exec_go)
        begin
            tail_reg   <= tail_next;
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = data_reg;
    assign stored_bits   = bgb_pkg::POS_W'(wc_reg);
    assign consumed_bits = bgb_pkg::POS_W'(rc_reg);
    assign all_consumed  = (rc_reg >= wc_reg);
    assign status        = status_reg;

endmodule

>>> design/bgb_store.sv
// Byte store of the bit-granular buffer, split into even and odd byte banks.
// Reads two neighboring bytes per cycle; the read data is registered.
// Depends on bgb_pkg.
module bgb_store #(
    parameter int NUM_BYTES = bgb_pkg::CAPACITY_BITS_DEFAULT / 8,
    parameter int BW = $clog2(NUM_BYTES)
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [BW-1:0]               rd_byte,
    output logic [2*bgb_pkg::DATA_W-1:0] rd_window,
    input  logic                        wr_en,
    input  logic                        wr_span,
    input  logic [BW-1:0]               wr_byte,
    input  logic [bgb_pkg::DATA_W-1:0]  wr_hi,
    input  logic [bgb_pkg::DATA_W-1:0]  wr_lo
);

    localparam int BANK_DEPTH = NUM_BYTES / 2 + 1;
    localparam int AW = $clog2(BANK_DEPTH);

    logic [bgb_pkg::DATA_W-1:0] mem_even [BANK_DEPTH];
    logic [bgb_pkg::DATA_W-1:0] mem_odd  [BANK_DEPTH];

    logic [BW:0]                rd_next;
    logic [BW:0]                wr_next;
    logic [AW-1:0]              rd_addr_even;
    logic [AW-1:0]              rd_addr_odd;
    logic [AW-1:0]              wr_addr_base;
    logic [AW-1:0]              wr_addr_next;
    logic [bgb_pkg::DATA_W-1:0] even_q_reg;
    logic [bgb_pkg::DATA_W-1:0] odd_q_reg;
    logic                       sel_reg;

    assign rd_next      = {1'b0, rd_byte} + 1'b1;
    assign wr_next      = {1'b0, wr_byte} + 1'b1;
    assign rd_addr_even = AW'(rd_next >> 1);
    assign rd_addr_odd  = AW'(rd_byte >> 1);
    assign wr_addr_base = AW'(wr_byte >> 1);
    assign wr_addr_next = AW'(wr_next >> 1);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            even_q_reg <= mem_even[rd_addr_even];
            odd_q_reg  <= mem_odd[rd_addr_odd];
            sel_reg    <= rd_byte[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (!wr_byte[0])
            begin
                mem_even[wr_addr_base] <= wr_hi;
            end
            else if (wr_span)
            begin
                mem_even[wr_addr_next] <= wr_lo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (wr_byte[0])
            begin
                mem_odd[wr_addr_base] <= wr_hi;
            end
            else if (wr_span)
            begin
                mem_odd[wr_addr_base] <= wr_lo;
            end
        end
    end

    assign rd_window = sel_reg ? {odd_q_reg, even_q_reg} : {even_q_reg, odd_q_reg};

endmodule

>>> design/bgb_checker.sv
// Port-level checker for the bit-granular buffer, bound to the top level.
// Depends on bgb_pkg and bit_granular_buffer_top.
module bgb_checker #(
    parameter int CAPACITY_BITS = bgb_pkg::CAPACITY_BITS_DEFAULT
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bgb_pkg::DATA_W-1:0]   read_data,
    input logic [bgb_pkg::POS_W-1:0]    stored_bits,
    input logic [bgb_pkg::POS_W-1:0]    consumed_bits,
    input logic                         all_consumed,
    input logic [bgb_pkg::STATUS_W-1:0] status
);

    localparam logic NARROW = (CAPACITY_BITS < 8192);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
            && $stable(stored_bits) && $stable(consumed_bits) && $stable(status))
        else $error("Result changed while stalled.");

    a_cursor_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && NARROW |-> consumed_bits <= stored_bits)
        else $error("Read cursor passed the stored bit count.");

    a_all_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && NARROW |-> all_consumed == (consumed_bits >= stored_bits))
        else $error("All-consumed flag disagrees with the counts.");

    a_status_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bgb_pkg::STAT_UNDERRUN || status == bgb_pkg::STAT_OVERFLOW)
            |-> read_data == '0)
        else $error("Nonzero read data on a failed item.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == bgb_pkg::STAT_OK || status == bgb_pkg::STAT_OVERFLOW
            || status == bgb_pkg::STAT_UNDERRUN)
        else $error("Undefined status code.");

endmodule

bind bit_granular_buffer_top bgb_checker #(
    .CAPACITY_BITS(CAPACITY_BITS)
) u_bgb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .stored_bits  (stored_bits),
    .consumed_bits(consumed_bits),
    .all_consumed (all_consumed),
    .status       (status)
);
